@@ rtl/keyed_login_stream_encoder_core_assert.svh @@
// Assertion macros for the keyed login stream encoder.
`ifndef KEYED_LOGIN_STREAM_ENCODER_CORE_ASSERT_SVH
`define KEYED_LOGIN_STREAM_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define KLS_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("kls: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define KLS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("kls: next-cycle check failed");

`else

`define KLS_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define KLS_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

@@ rtl/kls_pkg.sv @@
// Shared types, constants and functions of the keyed login stream encoder.
package kls_pkg;

  // Function codes of an input item
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  // Key store geometry
  localparam int KEY_MAX   = 5;
  localparam int KEY_IDX_W = 3;

  // Hash weights of the four address octets
  localparam logic [15:0] HASH_W_A = 16'd54;
  localparam logic [15:0] HASH_W_B = 16'd41;
  localparam logic [15:0] HASH_W_C = 16'd29;
  localparam logic [15:0] HASH_W_D = 16'd17;

  // Reciprocal of ten, exact for values below 81920 with a shift of 19
  localparam logic [31:0] DIV10_RECIP = 32'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Modulus of the running value
  localparam logic [8:0] MOD_VALUE = 9'd255;

  // ASCII digit prefix
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // Default depth of the byte queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic       func;
    logic [7:0] value;
  } kls_in_t;

  typedef struct packed {
    logic [6:0] hex_char;
    logic       last;
  } kls_out_t;

  // Byte handed from front to queue
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } kls_byte_req_t;

  // Head of the queue as seen by the back
  typedef struct packed {
    logic       avail;
    logic [7:0] data;
  } kls_qhead_t;

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [6:0] hex_of(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'd48 + {3'b000, nib};
    end else begin
      c = 7'd55 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

@@ rtl/kls_queue.sv @@
// Short byte queue between the front and the back of the encoder.
module kls_queue import kls_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  kls_byte_req_t req,
  output logic          full,
  output kls_qhead_t    head,
  input  logic          take
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign do_push = req.valid && !full;
  assign do_pop  = take && (count != '0);

  assign head.avail = (count != '0);
  assign head.data  = mem[rd_ptr];

  // Store pushed bytes
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= req.data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/kls_front.sv @@
// Front of the encoder: accepts items, builds the key, updates the running value.
module kls_front import kls_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  kls_in_t       item,
  input  logic [31:0]   server_ip,
  input  logic          q_full,
  output kls_byte_req_t req
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_KEY  = 2'b10
  } kls_front_st_t;

  kls_front_st_t        state;
  kls_front_st_t        state_next;
  logic [7:0]           running_value;
  logic [3:0]           key_rev [KEY_MAX];
  logic [KEY_IDX_W-1:0] key_length;
  logic [KEY_IDX_W-1:0] key_position;
  logic [15:0]          hash;
  logic [KEY_IDX_W-1:0] digit_cnt;

  logic                 accept;
  logic [15:0]          hash_in;
  logic [8:0]           sum;
  logic [7:0]           mod_val;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [7:0]           data_val;
  logic [31:0]          prod;
  logic [15:0]          quot;
  logic [15:0]          quot_x10;
  logic [3:0]           rem;
  logic                 key_done;

  assign full   = (state != ST_IDLE) || q_full;
  assign accept = push && !full;

  // Weighted hash of the address octets
  assign hash_in = HASH_W_A * {8'd0, server_ip[31:24]}
                 + HASH_W_B * {8'd0, server_ip[23:16]}
                 + HASH_W_C * {8'd0, server_ip[15:8]}
                 + HASH_W_D * {8'd0, server_ip[7:0]};

  // Running value update for a data byte
  assign sum     = {1'b0, running_value} + {1'b0, item.value};
  assign mod_val = (sum >= {MOD_VALUE[7:0], 1'b0}) ? 8'd0 :
                   (sum >= MOD_VALUE) ? 8'(sum - MOD_VALUE) : sum[7:0];
  assign key_idx  = key_length - KEY_IDX_W'(1) - key_position;
  assign data_val = mod_val ^ {ASCII_DIGIT_HI, key_rev[key_idx]};

  // One decimal digit per cycle, least significant first
  assign prod     = {16'd0, hash} * DIV10_RECIP;
  assign quot     = {3'b000, prod[31:DIV10_SHIFT]};
  assign quot_x10 = quot * 16'd10;
  assign rem      = 4'(hash - quot_x10);
  assign key_done = (quot == 16'd0) || (digit_cnt == KEY_IDX_W'(KEY_MAX - 1));

  // Hand the byte to emit to the queue
  always_comb begin
    req.valid = accept;
    req.data  = (item.func == FUNC_START) ? item.value : data_val;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item.func == FUNC_START) begin
          state_next = ST_KEY;
        end
      end
      ST_KEY: begin
        if (key_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Key state and running value
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      running_value <= 8'd0;
      key_length    <= KEY_IDX_W'(1);
      key_position  <= '0;
      digit_cnt     <= '0;
      for (int i = 0; i < KEY_MAX; i++) begin
        key_rev[i] <= 4'd0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        if (item.func == FUNC_START) begin
          running_value <= item.value;
          key_position  <= '0;
          digit_cnt     <= '0;
        end else begin
          running_value <= data_val;
          key_position  <= (key_position + KEY_IDX_W'(1) == key_length) ? '0 :
                           key_position + KEY_IDX_W'(1);
        end
      end
      if (state == ST_KEY) begin
        key_rev[digit_cnt] <= rem;
        digit_cnt          <= digit_cnt + KEY_IDX_W'(1);
        if (key_done) begin
          key_length <= digit_cnt + KEY_IDX_W'(1);
        end
      end
    end
  end

  // Hash register for the digit loop
  always_ff @(posedge clk) begin
    if (accept && item.func == FUNC_START) begin
      hash <= hash_in;
    end else if (state == ST_KEY) begin
      hash <= quot;
    end
  end

endmodule

@@ rtl/kls_back.sv @@
// Back of the encoder: splits each queued byte into two hex characters.
module kls_back import kls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  kls_qhead_t head,
  output logic       take,
  output logic       empty,
  input  logic       pop,
  output kls_out_t   result
);

  logic [7:0] byte_reg;
  logic       valid;
  logic       phase;
  logic       load;

  assign empty = !valid;
  assign load  = !valid || (pop && phase);
  assign take  = load && head.avail;

  assign result.hex_char = phase ? hex_of(byte_reg[3:0]) : hex_of(byte_reg[7:4]);
  assign result.last     = phase;

  // Load the next byte or step to the low nibble
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      valid <= head.avail;
      phase <= 1'b0;
    end else if (pop) begin
      phase <= 1'b1;
    end
  end

  // Hold the byte being emitted
  always_ff @(posedge clk) begin
    if (take) begin
      byte_reg <= head.data;
    end
  end

endmodule

@@ rtl/keyed_login_stream_encoder_core.sv @@
// Top level of the keyed login stream encoder.
//
//   channel   handshake        payload
//   -------   -------------    -------------------------------
//   item      push / full      func, value (kls_in_t)
//   result    pop / empty      hex_char, last (kls_out_t)
//   config    cfg_we           cfg_data, server address
//
// Each item yields two transactions on result, one character per cycle while pop is held,
// so the one-character result port sets the sustained item rate.
// A start item holds full high while the key is built one decimal digit per cycle;
// data items enter back to back while the queue has room.
// Reset clears the key to the single digit zero; no clearing pass.
// The byte queue lets intake continue while results are stalled.
`include "keyed_login_stream_encoder_core_assert.svh"

module keyed_login_stream_encoder_core import kls_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  kls_in_t     item,
  output logic        empty,
  input  logic        pop,
  output kls_out_t    result,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  logic [31:0]   server_ip;
  logic          q_full;
  kls_byte_req_t req;
  kls_qhead_t    head;
  logic          take;

  // Hold the server address register
  always_ff @(posedge clk) begin
    if (rst) begin
      server_ip <= 32'd0;
    end else if (cfg_we) begin
      server_ip <= cfg_data;
    end
  end

  kls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .server_ip (server_ip),
    .q_full    (q_full),
    .req       (req)
  );

  kls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .full (q_full),
    .head (head),
    .take (take)
  );

  kls_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .take   (take),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // A start transaction blocks intake while the key is built
  `KLS_ASSERT_NEXT(a_start_blocks, clk, rst, push && !full && item.func == FUNC_START, full)

  // The high character is always followed by its low character
  `KLS_ASSERT_NEXT(a_low_follows, clk, rst, pop && !empty && !result.last, !empty && result.last)

  // Every shown character is an uppercase hex digit
  `KLS_ASSERT_IMPLY(a_hex_range, clk, rst, !empty,
    (result.hex_char >= 7'd48 && result.hex_char <= 7'd57) ||
    (result.hex_char >= 7'd65 && result.hex_char <= 7'd70))

endmodule

@@ sim/tb_keyed_login_stream_encoder_core.sv @@
// Testbench of the keyed login stream encoder: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_keyed_login_stream_encoder_core;
  import kls_pkg::*;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        func;
    logic [7:0]  val;
    logic [31:0] ip;
    logic        typed;
    logic [7:0]  exp_byte;
  } stim_row_t;

  localparam int N_DIR_ROWS   = 25;
  localparam int RANDOM_ITEMS = 1450;
  localparam int SETTLE_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  kls_in_t     item = '0;
  logic        empty;
  logic        pop = 1'b0;
  kls_out_t    result;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  // Idle and stall rates in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Typed-in expectation of the transaction on the item port
  logic       cur_typed = 1'b0;
  logic [7:0] cur_typed_byte = '0;

  // Encoder shadow state
  logic [31:0] ip_shadow;
  logic [7:0]  run_val;
  logic [3:0]  key_dig [KEY_MAX];
  int          key_len;
  int          key_pos;

  kls_out_t pending_chars [$];
  int       error_count = 0;

  stim_row_t dir_rows [N_DIR_ROWS] = '{
    '{ROW_ITEM, FUNC_DATA,  8'h00, 32'h0, 1'b1, 8'h30},   // data before any start
    '{ROW_ITEM, FUNC_DATA,  8'hFF, 32'h0, 1'b1, 8'h00},
    '{ROW_ITEM, FUNC_START, 8'h00, 32'h0, 1'b1, 8'h00},
    '{ROW_ITEM, FUNC_START, 8'hFF, 32'h0, 1'b1, 8'hFF},
    '{ROW_ITEM, FUNC_DATA,  8'h7F, 32'h0, 1'b0, 8'h00},
    '{ROW_CFG,  FUNC_DATA,  8'h00, 32'hFFFF_FFFF, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_DATA,  8'h01, 32'h0, 1'b0, 8'h00},   // key kept until next start
    '{ROW_ITEM, FUNC_START, 8'hA5, 32'h0, 1'b1, 8'hA5},
    '{ROW_ITEM, FUNC_DATA,  8'h00, 32'h0, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_DATA,  8'hFF, 32'h0, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_DATA,  8'h80, 32'h0, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_DATA,  8'h55, 32'h0, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_DATA,  8'hAA, 32'h0, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_DATA,  8'h01, 32'h0, 1'b0, 8'h00},   // wraps the five-digit key
    '{ROW_CFG,  FUNC_DATA,  8'h00, 32'h0100_0000, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_START, 8'h5A, 32'h0, 1'b1, 8'h5A},
    '{ROW_ITEM, FUNC_DATA,  8'hFE, 32'h0, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_DATA,  8'h10, 32'h0, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_DATA,  8'hEF, 32'h0, 1'b0, 8'h00},
    '{ROW_CFG,  FUNC_DATA,  8'h00, 32'h0000_0000, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_START, 8'h12, 32'h0, 1'b1, 8'h12},   // zero hash gives key "0"
    '{ROW_ITEM, FUNC_DATA,  8'hFF, 32'h0, 1'b0, 8'h00},
    '{ROW_CFG,  FUNC_DATA,  8'h00, 32'h0000_0001, 1'b0, 8'h00},
    '{ROW_ITEM, FUNC_START, 8'hC3, 32'h0, 1'b1, 8'hC3},
    '{ROW_ITEM, FUNC_DATA,  8'h3C, 32'h0, 1'b0, 8'h00}
  };

  keyed_login_stream_encoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [6:0] ascii_hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? 7'd48 + 7'(nib) : 7'd55 + 7'(nib);
  endfunction

  // Rebuild the key from the address hash, most significant digit first
  task automatic load_key();
    int h;
    int n;
    int rev [KEY_MAX];
    h = 54 * int'(ip_shadow[31:24]) + 41 * int'(ip_shadow[23:16])
      + 29 * int'(ip_shadow[15:8]) + 17 * int'(ip_shadow[7:0]);
    n = 0;
    do begin
      rev[n] = h % 10;
      h = h / 10;
      n++;
    end while (h != 0 && n < KEY_MAX);
    for (int i = 0; i < KEY_MAX; i++) key_dig[i] = 4'd0;
    for (int i = 0; i < n; i++) key_dig[i] = 4'(rev[n - 1 - i]);
    key_len = n;
    key_pos = 0;
  endtask

  // Advance the shadow state by one item and return the byte to be emitted
  task automatic encode_step(input logic f, input logic [7:0] v, output logic [7:0] b);
    int pos;
    int s;
    if (f == FUNC_START) begin
      load_key();
      run_val = v;
    end else begin
      pos = (key_pos >= key_len) ? 0 : key_pos;
      s = (int'(run_val) + int'(v)) % 255;
      s = s ^ (48 + int'(key_dig[pos]));
      run_val = s[7:0];
      pos++;
      key_pos = (pos >= key_len) ? 0 : pos;
    end
    b = run_val;
  endtask

  // Track accepted transactions, predict on the item side, check on the result side
  always @(posedge clk) begin
    logic [7:0] pb;
    kls_out_t   want;
    if (rst) begin
      ip_shadow = '0;
      run_val = '0;
      for (int i = 0; i < KEY_MAX; i++) key_dig[i] = 4'd0;
      key_len = 1;
      key_pos = 0;
      pending_chars.delete();
    end else begin
      if (cfg_we) ip_shadow = cfg_data;
      if (push && !full) begin
        encode_step(item.func, item.value, pb);
        if (cur_typed) pb = cur_typed_byte;
        pending_chars.push_back('{hex_char: ascii_hex_digit(pb[7:4]), last: 1'b0});
        pending_chars.push_back('{hex_char: ascii_hex_digit(pb[3:0]), last: 1'b1});
      end
      if (pop && !empty) begin
        if (pending_chars.size() == 0) begin
          error_count++;
          $display("%0t: result with no transaction pending, expected none, got %h/%b",
                   $time, result.hex_char, result.last);
        end else begin
          want = pending_chars.pop_front();
          if (result.hex_char !== want.hex_char) begin
            error_count++;
            $display("%0t: hex_char mismatch, expected %h, got %h",
                     $time, want.hex_char, result.hex_char);
          end
          if (result.last !== want.last) begin
            error_count++;
            $display("%0t: last mismatch, expected %b, got %b",
                     $time, want.last, result.last);
          end
        end
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Offer one item until it is taken, idling at random in between
  task automatic send_item(input logic f, input logic [7:0] v, input logic typed,
                           input logic [7:0] typed_byte);
    bit done;
    done = 0;
    while (!done) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        item <= '{func: f, value: v};
        cur_typed = typed;
        cur_typed_byte = typed_byte;
        @(posedge clk);
        if (!full) done = 1;
      end
    end
  endtask

  // Drain all results, let the block settle, then write the address register
  task automatic write_server_ip(input logic [31:0] ip);
    @(negedge clk);
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= ip;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int sent;
    int chunk;
    int chunk_len;
    logic [31:0] ip;
    logic f;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int r = 0; r < N_DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_server_ip(dir_rows[r].ip);
      end else begin
        send_item(dir_rows[r].func, dir_rows[r].val, dir_rows[r].typed, dir_rows[r].exp_byte);
      end
    end

    // Random messages: mostly a start followed by data, some stray starts and headless runs
    sent = 0;
    chunk = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 6))
        0: ip = 32'h0000_0000;
        1: ip = 32'hFFFF_FFFF;
        2: ip = 32'($urandom_range(0, 1));
        3: ip = {24'd0, 8'($urandom_range(0, 5))};
        4: ip = {24'd0, 8'($urandom_range(0, 255))};
        default: ip = $urandom;
      endcase
      write_server_ip(ip);
      case (chunk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      chunk_len = $urandom_range(20, 80);
      for (int k = 0; k < chunk_len; k++) begin
        if (k == 0) f = ($urandom_range(0, 9) != 0) ? FUNC_START : FUNC_DATA;
        else f = ($urandom_range(0, 99) < 6) ? FUNC_START : FUNC_DATA;
        send_item(f, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
        sent++;
      end
      chunk++;
    end

    // Wait out every expected result, then the tail latency
    @(negedge clk);
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
